// ----- src/hbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg: shared definitions of the heightmap bilinear sampler
// Field layouts of the stream payloads, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // texel store geometry
    localparam int ADDR_W  = 16;
    localparam int TEXEL_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MAP_DIM_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WORLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 3'd4;

    // request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // input payload, first member in the highest bits
    typedef struct packed {
        logic signed [31:0]  z_pos;
        logic signed [31:0]  x_pos;
        logic [TEXEL_W-1:0]  texel_raw;
        logic [ADDR_W-1:0]   texel_index;
    } t_in_data;

    localparam int IN_DATA_W  = $bits(t_in_data);
    localparam int OUT_DATA_W = 32;

    // normalized coordinate constants, Q1.32 in 33 bits
    localparam logic [32:0] T_HALF = 33'h0_8000_0000;
    localparam logic [32:0] T_ONE  = 33'h1_0000_0000;

    // scaled raw value limit and height saturation
    localparam int          Q_W     = 35;
    localparam logic [Q_W-1:0] Q_MAX = 35'h4_0000_0000;
    localparam logic [31:0] HEIGHT_MAX = 32'h7FFF_FFFF;

    // result queue
    localparam int OUT_DEPTH = 16;
    localparam int PTR_W     = 4;
    localparam int CNT_W     = 5;

endpackage

// ----- src/hbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/heightmap_bilinear_sampler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler: terrain height lookup with bilinear filtering
// Loads 16-bit texels into a store and answers height queries at world
// positions with clamp-to-edge bilinear interpolation.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one transaction per request. tuser = 0 loads texel_raw at
//   texel_index (no result), tuser = 1 queries x_pos/z_pos (one result).
//   m_axis: one 32-bit signed Q16.16 height per query, in request order.
//   cfg: register writes (index, data), always ready; write only while idle.
// Throughput and pipeline
//   One request per cycle while s_axis_tready is high. A query result
//   passes the 12-stage arithmetic pipeline around the two registered-read
//   texel RAMs and then waits in the result queue.
//   A load is written into both RAM copies in the same stage where queries
//   issue their reads, so a later query always sees an earlier load.
// Reset and back-pressure
//   Reset restores the register defaults and empties the pipeline and the
//   result queue; texel contents are undefined until loaded.
//   Results wait in a 16-entry queue; s_axis_tready drops only when the
//   queries in flight plus the queued results would fill it.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: texel_index, texel_raw, x_pos, z_pos
    input  logic [hbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type
    input  logic                            s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: height_out
    output logic [hbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import hbs_pkg::*;

    // derived widths
    localparam int SW   = $clog2(MAX_SIDE + 1);          // side value
    localparam int IW   = $clog2(MAX_SIDE);              // texel coordinate
    localparam int UW   = 33 + SW;                       // texel-space position
    localparam int AW2  = IW + SW;                       // row base product
    localparam int TW   = TEXEL_W + FRAC_BITS;           // horizontal blend
    localparam int BW   = TEXEL_W + 2 * FRAC_BITS;       // vertical blend
    localparam int RW   = TW;                            // rounded raw value
    localparam int SH   = FRAC_BITS + 16;                // scale shift
    localparam int PPW  = RW + 16;                       // partial product
    localparam int SUMW = RW + 33;                       // low partial sum
    localparam int FW   = RW + 49;                       // full scaled product
    localparam int QFW  = FW - SH;                       // shifted product
    localparam int NQ   = 12;                            // query stages
    localparam int NL   = 5;                             // load stages

    localparam logic [FRAC_BITS:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUMW-1:0]    RND   = SUMW'(1) << (SH - 1);

    // configuration registers
    logic [MAP_DIM_W-1:0] r_map_w;
    logic [MAP_DIM_W-1:0] r_map_h;
    logic [31:0]          r_inv_ws;
    logic signed [31:0]   r_min_h;
    logic [47:0]          r_hscale;

    // effective sides, clamped to the supported range
    function automatic logic [SW-1:0] eff_side(input logic [MAP_DIM_W-1:0] v);
        if (v < MAP_DIM_W'(2)) begin
            return SW'(2);
        end
        if (32'(v) > 32'(MAX_SIDE)) begin
            return SW'(MAX_SIDE);
        end
        return SW'(v);
    endfunction

    logic [SW-1:0] side    [2];
    logic [SW-1:0] side_m1 [2];

    always_comb begin
        side[0]    = eff_side(r_map_w);
        side[1]    = eff_side(r_map_h);
        side_m1[0] = side[0] - SW'(1);
        side_m1[1] = side[1] - SW'(1);
    end

    // handshakes
    t_in_data       in_data;
    logic           acc;
    logic           acc_query;
    logic           acc_load;
    logic           pop;
    logic           push;
    logic           cfg_we;

    logic [CNT_W-1:0] r_credit;
    logic [CNT_W-1:0] n_credit;
    logic [CNT_W-1:0] r_fifo_cnt;
    logic [CNT_W-1:0] n_fifo_cnt;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [NQ-1:0]    r_qv;
    logic [NL-1:0]    r_lv;

    assign in_data       = t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_credit < CNT_W'(OUT_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign acc_query     = acc && (s_axis_tuser == REQ_QUERY);
    assign acc_load      = acc && (s_axis_tuser == REQ_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid && o_cfg_ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w  <= MAP_DIM_W'(256);
            r_map_h  <= MAP_DIM_W'(256);
            r_inv_ws <= 32'd65536;
            r_min_h  <= 32'sd0;
            r_hscale <= 48'd0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:    r_map_w  <= i_cfg_data[MAP_DIM_W-1:0];
                CFG_MAP_HEIGHT:   r_map_h  <= i_cfg_data[MAP_DIM_W-1:0];
                CFG_INV_WORLD:    r_inv_ws <= i_cfg_data[31:0];
                CFG_MIN_HEIGHT:   r_min_h  <= $signed(i_cfg_data[31:0]);
                CFG_HEIGHT_SCALE: r_hscale <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // stage valid shift lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
            r_lv <= '0;
        end else begin
            r_qv <= {r_qv[NQ-2:0], acc_query};
            r_lv <= {r_lv[NL-2:0], acc_load};
        end
    end

    // load fields travel to the RAM write stage
    logic [ADDR_W-1:0]  r_ld_idx [NL];
    logic [TEXEL_W-1:0] r_ld_raw [NL];

    always_ff @(posedge i_clk) begin
        r_ld_idx[0] <= in_data.texel_index;
        r_ld_raw[0] <= in_data.texel_raw;
        for (int i = 1; i < NL; i++) begin
            r_ld_idx[i] <= r_ld_idx[i-1];
            r_ld_raw[i] <= r_ld_raw[i-1];
        end
    end

    // axis pipeline, lane 0 is x (columns), lane 1 is z (rows)
    logic [31:0]          in_coord  [2];
    logic                 r_s1_neg  [2];
    logic [31:0]          r_s1_mag  [2];
    logic                 r_s2_neg  [2];
    logic [63:0]          r_s2_prod [2];
    logic [32:0]          r_s3_t    [2];
    logic [UW-1:0]        r_s4_u    [2];
    logic [IW-1:0]        r_s5_i0   [2];
    logic [IW-1:0]        r_s5_i1   [2];
    logic [FRAC_BITS-1:0] r_s5_f    [2];
    logic [FRAC_BITS-1:0] r_s6_f    [2];

    assign in_coord[0] = in_data.x_pos;
    assign in_coord[1] = in_data.z_pos;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            logic [64:0] pos_sum;
            logic [IW-1:0] a;
            logic [SW:0] a_inc;
            // magnitude and sign of the world coordinate
            r_s1_neg[k] <= in_coord[k][31];
            r_s1_mag[k] <= in_coord[k][31] ? (~in_coord[k] + 32'd1) : in_coord[k];
            // scale by the reciprocal world size
            r_s2_neg[k]  <= r_s1_neg[k];
            r_s2_prod[k] <= 64'(r_s1_mag[k]) * 64'(r_inv_ws);
            // offset by one half and clamp to [0, 1]
            pos_sum = 65'(r_s2_prod[k]) + 65'(T_HALF);
            if (r_s2_neg[k]) begin
                if (r_s2_prod[k] >= 64'(T_HALF)) begin
                    r_s3_t[k] <= 33'd0;
                end else begin
                    r_s3_t[k] <= T_HALF - 33'(r_s2_prod[k][31:0]);
                end
            end else if (pos_sum > 65'(T_ONE)) begin
                r_s3_t[k] <= T_ONE;
            end else begin
                r_s3_t[k] <= pos_sum[32:0];
            end
            // texel-space position
            r_s4_u[k] <= UW'(r_s3_t[k]) * UW'(side_m1[k]);
            // neighbor coordinates and fraction, +1 neighbor clamped at the edge
            a     = r_s4_u[k][32 +: IW];
            a_inc = (SW + 1)'(a) + (SW + 1)'(1);
            r_s5_i0[k] <= a;
            r_s5_i1[k] <= (a_inc < (SW + 1)'(side[k])) ? IW'(a_inc) : IW'(side_m1[k]);
            r_s5_f[k]  <= r_s4_u[k][31 -: FRAC_BITS];
            // fraction waits for the RAM read
            r_s6_f[k]  <= r_s5_f[k];
        end
    end

    // texel addresses, row * width + column wrapped to the store size
    logic [AW2-1:0]    row0_base;
    logic [AW2-1:0]    row1_base;
    logic [ADDR_W-1:0] addr00;
    logic [ADDR_W-1:0] addr01;
    logic [ADDR_W-1:0] addr10;
    logic [ADDR_W-1:0] addr11;

    always_comb begin
        row0_base = AW2'(r_s5_i0[1]) * AW2'(side[0]);
        row1_base = AW2'(r_s5_i1[1]) * AW2'(side[0]);
        addr00    = ADDR_W'(row0_base + AW2'(r_s5_i0[0]));
        addr01    = ADDR_W'(row0_base + AW2'(r_s5_i1[0]));
        addr10    = ADDR_W'(row1_base + AW2'(r_s5_i0[0]));
        addr11    = ADDR_W'(row1_base + AW2'(r_s5_i1[0]));
    end

    // two copies of the texel store, one per row of the 2x2 footprint;
    // loads write here in the same stage that queries read
    logic [TEXEL_W-1:0] tex00;
    logic [TEXEL_W-1:0] tex01;
    logic [TEXEL_W-1:0] tex10;
    logic [TEXEL_W-1:0] tex11;

    hbs_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (1 << ADDR_W)
    ) u_ram_row0 (
        .i_clk     (i_clk),
        .i_we      (r_lv[NL-1]),
        .i_waddr   (r_ld_idx[NL-1]),
        .i_wdata   (r_ld_raw[NL-1]),
        .i_raddr_a (addr00),
        .i_raddr_b (addr01),
        .o_rdata_a (tex00),
        .o_rdata_b (tex01)
    );

    hbs_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (1 << ADDR_W)
    ) u_ram_row1 (
        .i_clk     (i_clk),
        .i_we      (r_lv[NL-1]),
        .i_waddr   (r_ld_idx[NL-1]),
        .i_wdata   (r_ld_raw[NL-1]),
        .i_raddr_a (addr10),
        .i_raddr_b (addr11),
        .o_rdata_a (tex10),
        .o_rdata_b (tex11)
    );

    // blend and scale pipeline
    logic [TW-1:0]        r_s7_top;
    logic [TW-1:0]        r_s7_bot;
    logic [FRAC_BITS-1:0] r_s7_fz;
    logic [BW-1:0]        r_s8_blend;
    logic [RW-1:0]        r_s9_rawq;
    logic [PPW-1:0]       r_s10_pp [3];
    logic [SUMW-1:0]      r_s11_sum;
    logic [PPW-1:0]       r_s11_pp2;
    logic [Q_W-1:0]       r_s12_q;

    always_ff @(posedge i_clk) begin
        logic [TW:0]     top_sum;
        logic [TW:0]     bot_sum;
        logic [BW:0]     blend_sum;
        logic [RW:0]     rawq_sum;
        logic [FW-1:0]   full;
        logic [QFW-1:0]  qfull;
        // horizontal blend of both rows
        top_sum = (TW + 1)'(tex00) * (TW + 1)'(W_ONE - (FRAC_BITS + 1)'(r_s6_f[0]))
                + (TW + 1)'(tex01) * (TW + 1)'(r_s6_f[0]);
        bot_sum = (TW + 1)'(tex10) * (TW + 1)'(W_ONE - (FRAC_BITS + 1)'(r_s6_f[0]))
                + (TW + 1)'(tex11) * (TW + 1)'(r_s6_f[0]);
        r_s7_top <= top_sum[TW-1:0];
        r_s7_bot <= bot_sum[TW-1:0];
        r_s7_fz  <= r_s6_f[1];
        // vertical blend
        blend_sum = (BW + 1)'(r_s7_top) * (BW + 1)'(W_ONE - (FRAC_BITS + 1)'(r_s7_fz))
                  + (BW + 1)'(r_s7_bot) * (BW + 1)'(r_s7_fz);
        r_s8_blend <= blend_sum[BW-1:0];
        // round half up back to FRAC_BITS fraction bits
        rawq_sum  = (RW + 1)'(r_s8_blend[BW-1:FRAC_BITS])
                  + (RW + 1)'(r_s8_blend[FRAC_BITS-1]);
        r_s9_rawq <= rawq_sum[RW-1:0];
        // partial products with 16-bit slices of the height scale
        for (int k = 0; k < 3; k++) begin
            r_s10_pp[k] <= PPW'(r_s9_rawq) * PPW'(r_hscale[16*k +: 16]);
        end
        // low partial sum with the rounding constant
        r_s11_sum <= SUMW'(r_s10_pp[0]) + (SUMW'(r_s10_pp[1]) << 16) + RND;
        r_s11_pp2 <= r_s10_pp[2];
        // full product, shift to Q16.16 and limit
        full  = FW'(r_s11_sum) + (FW'(r_s11_pp2) << 32);
        qfull = full[FW-1:SH];
        r_s12_q <= (qfull > QFW'(Q_MAX)) ? Q_MAX : qfull[Q_W-1:0];
    end

    // offset by the minimum height and saturate
    logic [Q_W+1:0]  total;
    logic [31:0]     height;

    always_comb begin
        total  = {{(Q_W - 30){r_min_h[31]}}, r_min_h} + {2'b00, r_s12_q};
        height = (!total[Q_W+1] && (total[Q_W:31] != '0)) ? HEIGHT_MAX : total[31:0];
    end

    // result queue
    logic [OUT_DATA_W-1:0] r_fifo_mem [OUT_DEPTH];

    assign push          = r_qv[NQ-1];
    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = r_fifo_mem[r_rd_ptr];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_mem[r_wr_ptr] <= height;
        end
    end

    // queue occupancy and credit for queries in flight
    always_comb begin
        n_fifo_cnt = r_fifo_cnt + CNT_W'(push) - CNT_W'(pop);
        n_credit   = r_credit + CNT_W'(acc_query) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_cnt <= '0;
            r_credit   <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            r_credit   <= n_credit;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    // credit accounts for every query in the pipeline and every queued result
    a_credit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_qv) + int'(r_fifo_cnt)) == int'(r_credit))
        else $error("credit does not match queries in flight");

    // credit never passes the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CNT_W'(OUT_DEPTH))
        else $error("credit exceeds result queue depth");

    // a finished query always finds room in the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((r_fifo_cnt < CNT_W'(OUT_DEPTH)) || pop))
        else $error("result queue overflow");

    // an accepted query leaves credit raised in the next cycle unless popped
    a_credit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_query && !pop) |=> (r_credit == $past(r_credit) + CNT_W'(1)))
        else $error("credit not raised for accepted query");
`endif

endmodule

// ----- tb/tb_heightmap_bilinear_sampler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_sampler: self-checking bench of the terrain sampler
// Fills the low part of the texel store that every map the bench sets covers and
// then sends directed and random load and query transactions under a range
// of register settings, with random idling and long back-pressure on both
// streams. Every query height is predicted in fixed point and compared in
// order against the result stream.
// ----------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler;
    import hbs_pkg::*;

    localparam int          FRAC        = 16;
    localparam int          SIDE_LIMIT  = 256;
    localparam int          LATENCY     = 12;
    localparam int          IDLE_PCT    = 35;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned LIMIT       = 1_000_000;
    // maps the bench sets never span more texels than this, so queries read loaded texels only
    localparam int          PRELOAD_N   = 512;

    // interpolation predictor, texel copy and queue of awaited heights
    class height_tracker;
        bit [TEXEL_W-1:0] texels [65536];
        bit [8:0]         map_w;
        bit [8:0]         map_h;
        bit [31:0]        inv_size;
        bit [31:0]        base_height;
        bit [47:0]        step_scale;
        bit [31:0]        pending_heights [$];
        int               errors;
        int               checked;
        int               queries;
        int               loads;

        function new();
            map_w       = 9'd256;
            map_h       = 9'd256;
            inv_size    = 32'h0001_0000;
            base_height = 32'd0;
            step_scale  = 48'd0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MAP_WIDTH:    map_w       = val[8:0];
                CFG_MAP_HEIGHT:   map_h       = val[8:0];
                CFG_INV_WORLD:    inv_size    = val[31:0];
                CFG_MIN_HEIGHT:   base_height = val[31:0];
                CFG_HEIGHT_SCALE: step_scale  = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_side(bit [8:0] v);
            if (v < 9'd2) return 2;
            if (v > 9'(SIDE_LIMIT)) return SIDE_LIMIT;
            return int'(v);
        endfunction

        // world coordinate to normalized Q1.32, clamped to [0, 1]
        function bit [32:0] norm_coord(bit [31:0] c);
            bit [32:0] mag;
            bit [63:0] p;
            mag = c[31] ? (33'd0 - {c[31], c}) : {1'b0, c};
            p = 64'(mag) * 64'(inv_size);
            if (c[31]) begin
                if (p >= 64'(T_HALF)) return 33'd0;
                return T_HALF - p[32:0];
            end
            p = p + 64'(T_HALF);
            if (p > 64'(T_ONE)) return T_ONE;
            return p[32:0];
        endfunction

        // texel pair and blend fraction along one axis
        function void map_axis(bit [31:0] c, int unsigned side, output int unsigned lo_i,
                               output int unsigned hi_i, output bit [63:0] frac);
            bit [63:0] u;
            u = 64'(norm_coord(c)) * 64'(side - 1);
            lo_i = u[63:32];
            hi_i = (lo_i + 1 < side) ? lo_i + 1 : side - 1;
            frac = 64'(u[31 -: FRAC]);
        endfunction

        function bit [63:0] texel_at(int unsigned col, int unsigned row, int unsigned w);
            return 64'(texels[16'(row * w + col)]);
        endfunction

        function bit [31:0] predict_height(bit [31:0] x, bit [31:0] z);
            int unsigned      w, h, x0, x1, z0, z1;
            bit [63:0]        fx, fz, one, top, bot, blend, rawq;
            bit [127:0]       prod;
            bit [Q_W-1:0]     add;
            bit signed [63:0] total;
            w = clamp_side(map_w);
            h = clamp_side(map_h);
            map_axis(x, w, x0, x1, fx);
            map_axis(z, h, z0, z1, fz);
            one   = 64'd1 << FRAC;
            top   = texel_at(x0, z0, w) * (one - fx) + texel_at(x1, z0, w) * fx;
            bot   = texel_at(x0, z1, w) * (one - fx) + texel_at(x1, z1, w) * fx;
            blend = top * (one - fz) + bot * fz;
            rawq  = (blend >> FRAC) + ((blend >> (FRAC - 1)) & 64'd1);
            // raw times scale, rounded half up to Q.16 and limited
            prod = 128'(rawq) * 128'(step_scale) + (128'd1 << (FRAC + 15));
            prod = prod >> (FRAC + 16);
            add  = (prod > 128'(Q_MAX)) ? Q_MAX : prod[Q_W-1:0];
            total = $signed({{32{base_height[31]}}, base_height}) +
                    $signed({{(64 - Q_W){1'b0}}, add});
            if (total > $signed({32'd0, HEIGHT_MAX})) total = $signed({32'd0, HEIGHT_MAX});
            return total[31:0];
        endfunction

        function void note_request(bit kind, t_in_data d);
            if (kind == REQ_LOAD) begin
                texels[d.texel_index] = d.texel_raw;
                loads++;
            end else begin
                pending_heights.push_back(predict_height(d.x_pos, d.z_pos));
                queries++;
            end
        endfunction

        function void check_height(bit [31:0] got);
            bit [31:0] want;
            if (pending_heights.size() == 0) begin
                $error("height_out: expected no result, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = pending_heights.pop_front();
            checked++;
            if (got != want) begin
                $error("height_out: expected %0d, actual %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function int pending();
            return pending_heights.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    height_tracker tracker = new();

    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    int          hold_reqs   = 0;
    int          holds_done  = 0;
    int          settings_cnt = 0;
    int unsigned coord_span  = 32'h0000_8000;
    int unsigned cycles      = 0;

    heightmap_bilinear_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // transaction monitor on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tracker.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) tracker.check_height(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) tracker.set_reg(i_cfg_index, i_cfg_data);
        end
    end

    // result sink with random stalls and requested long hold-offs
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_heightmap_bilinear_sampler: FAIL");
        $finish;
    end

    function automatic t_in_data make_item(logic [15:0] idx, logic [15:0] raw,
                                           logic [31:0] x, logic [31:0] z);
        t_in_data d;
        d.texel_index = idx;
        d.texel_raw   = raw;
        d.x_pos       = x;
        d.z_pos       = z;
        return d;
    endfunction

    // mostly inside the map, some past the edges, some anywhere
    function automatic logic [31:0] random_coord();
        logic [31:0] mag;
        if ($urandom_range(0, 9) == 0) return $urandom;
        mag = $urandom_range(0, coord_span);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic send_item(input logic kind, input t_in_data d);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending until all heights are back and the pipeline is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [8:0] w, input logic [8:0] h,
                                  input logic [31:0] inv, input logic [31:0] mn,
                                  input logic [47:0] sc);
        logic [63:0] span;
        write_reg(CFG_MAP_WIDTH, 48'(w));
        write_reg(CFG_MAP_HEIGHT, 48'(h));
        write_reg(CFG_INV_WORLD, 48'(inv));
        write_reg(CFG_MIN_HEIGHT, 48'(mn));
        write_reg(CFG_HEIGHT_SCALE, sc);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        // half a world is 2^31 / inv, reach a bit beyond it
        span = 64'h1_0000_0000 / 64'(inv == 0 ? 32'd1 : inv);
        span = span * 5 / 8;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        coord_span = span[31:0];
        settings_cnt++;
    endtask

    task automatic random_settings();
        logic [8:0]  w, h, tmp;
        logic [31:0] inv, mag, mn;
        logic [63:0] sc;
        int unsigned w_eff, h_max;
        // one side anywhere, the other limited so the map stays in loaded texels
        case ($urandom_range(0, 3))
            0:       w_eff = 2;
            1:       w_eff = SIDE_LIMIT;
            default: w_eff = $urandom_range(2, SIDE_LIMIT);
        endcase
        h_max = PRELOAD_N / w_eff;
        if (h_max > SIDE_LIMIT) h_max = SIDE_LIMIT;
        w = 9'(w_eff);
        h = 9'($urandom_range(2, h_max));
        // register values outside the legal range clamp back to the same side
        if (w_eff == 2 && $urandom_range(0, 1) == 0) w = 9'($urandom_range(0, 1));
        if (w_eff == SIDE_LIMIT && $urandom_range(0, 1) == 0)
            w = 9'($urandom_range(SIDE_LIMIT, 511));
        if ($urandom_range(0, 1) == 0) begin
            tmp = w;
            w   = h;
            h   = tmp;
        end
        inv = $urandom >> $urandom_range(0, 31);
        if (inv == 0) inv = 32'd1;
        if ($urandom_range(0, 1) == 0) begin
            mn = $urandom;
        end else begin
            mag = $urandom >> $urandom_range(1, 31);
            mn = $urandom_range(0, 1) ? -mag : mag;
        end
        sc = {$urandom, $urandom} >> $urandom_range(16, 63);
        apply_settings(w, h, inv, mn, sc[47:0]);
    endtask

    // every texel that any map the bench sets covers, so no query reads an unwritten one
    task automatic preload_store();
        for (int i = 0; i < PRELOAD_N; i++)
            send_item(REQ_LOAD, make_item(16'(i), 16'($urandom), $urandom, $urandom));
    endtask

    task automatic random_items(input int n);
        logic kind;
        repeat (n) begin
            kind = ($urandom_range(0, 99) < 20) ? REQ_LOAD : REQ_QUERY;
            send_item(kind, make_item(16'($urandom_range(0, PRELOAD_N - 1)), 16'($urandom),
                                      random_coord(), random_coord()));
        end
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic stall_burst();
        hold_reqs++;
        tx_idle_on = 1'b0;
        repeat (24)
            send_item(REQ_QUERY, make_item(16'($urandom), 16'($urandom),
                                           random_coord(), random_coord()));
        tx_idle_on = 1'b1;
    endtask

    // expects a 16 x 16 map in a unit world
    task automatic directed_items();
        // corner texels at both raw extremes
        send_item(REQ_LOAD,  make_item(16'd0, 16'h0000, 32'h0, 32'h0));
        send_item(REQ_LOAD,  make_item(16'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(REQ_LOAD,  make_item(16'd15, 16'hFFFF, 32'h0, 32'h0));
        send_item(REQ_LOAD,  make_item(16'd240, 16'h0000, 32'h0, 32'h0));
        // exact lower and upper edges, upper neighbor clamped
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, -32'sh8000, -32'sh8000));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h8000, 32'h8000));
        // coordinates far outside the map on opposite sides
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF));
        // load immediately followed by a query that reads it at the center
        send_item(REQ_LOAD,  make_item(16'd136, 16'hFFFF, 32'h0, 32'h0));
        send_item(REQ_QUERY, make_item(16'hFFFF, 16'hFFFF, 32'h0, 32'h0));
        // just inside the edge and small offsets around the center
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h7FFF, 32'h7FFF));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h1, 32'hFFFF_FFFF));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h4000, -32'sh4000));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, -32'sh7FFF, 32'h1234));
        repeat (4)
            send_item(REQ_QUERY, make_item(16'h0, 16'h0, random_coord(), random_coord()));
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        preload_store();
        // reset register values give the minimum height everywhere
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, -32'sh8000, -32'sh8000));
        send_item(REQ_QUERY, make_item(16'h0, 16'h0, 32'h8000_0000, 32'h8000_0000));
        wait_idle();

        // unit world, one raw step per unit height, saturates at the top
        apply_settings(9'd16, 9'd16, 32'h0001_0000, 32'h0, 48'h1_0000_0000);
        directed_items();
        wait_idle();

        // register extremes, side values outside the legal range
        apply_settings(9'd0, 9'h1FF, 32'd1, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
        random_items(10);
        wait_idle();
        apply_settings(9'h1FF, 9'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'd0);
        random_items(10);
        wait_idle();
        apply_settings(9'd2, 9'd256, 32'h0000_8000, 32'h0, 48'h1_0000_0000);
        random_items(10);
        wait_idle();
        apply_settings(9'd256, 9'd2, 32'h0004_0000, 32'hFFF0_0000, 48'h0000_8000_0000);
        random_items(10);
        wait_idle();

        // random settings with back-pressure, a quiet stretch and a pause
        for (int p = 0; p < 6; p++) begin
            random_settings();
            if (p == 3) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_items((p == 3) ? 30 : 6);
            if (p == 1) stall_burst();
            if (p == 4) wait_idle();
            random_items((p == 3) ? 30 : 6);
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
            wait_idle();
        end

        $display("run: %0d loads, %0d queries, %0d heights checked", tracker.loads,
                 tracker.queries, tracker.checked);
        $display("run: %0d register settings incl. side, scale and offset extremes, %0d stalls",
                 settings_cnt, holds_done);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_heightmap_bilinear_sampler: PASS");
        end else begin
            if (tracker.pending() != 0)
                $error("height_out: expected %0d more results, actual none", tracker.pending());
            $display("tb_heightmap_bilinear_sampler: FAIL");
        end
        $finish;
    end

endmodule
